/* hw/rtl/multiword_float_add_mul_assert.svh */
// assertion macros used by the checker
`ifndef MULTIWORD_FLOAT_ADD_MUL_ASSERT_SVH
`define MULTIWORD_FLOAT_ADD_MUL_ASSERT_SVH

// same-cycle implication
`define MFAM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MFAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mfam_pkg.sv */
`timescale 1ns / 1ps
package mfam_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = 32;
	localparam int EXP_W = 16;
	localparam int IN_TDATA_W = 168;
	localparam int OUT_TDATA_W = 88;
	localparam int NORM_LZ = 2;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_RSV = 2'd3;

	typedef enum logic [4:0] {
		ST_LOAD, ST_FILL, ST_CHK_RD, ST_CHK, ST_NEG_RD, ST_NEG_WR, ST_ALIGN,
		ST_SH_RDH, ST_SH_RDL, ST_SH_WR, ST_ADD_RD, ST_ADD_WR, ST_ABS_RD, ST_ABS_WR,
		ST_MUL_RD, ST_MUL_PP, ST_MUL_ADD, ST_MUL_COL, ST_MUL_TOP, ST_NORM,
		ST_OUT_RD, ST_OUT_VAL
	} st_t;

	typedef enum logic [1:0] {
		RS_A, RS_B, RS_P
	} ram_sel_t;

	function automatic logic [5:0] clz64(input logic [WORD_W-1:0] w);
		logic [5:0] n;
		n = 6'd0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) begin
				n = 6'(WORD_W - 1 - i);
			end
		end
		return n;
	endfunction

endpackage

/* hw/rtl/mfam_ram.sv */
`timescale 1ns / 1ps
module mfam_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* hw/rtl/multiword_float_add_mul.sv */
`timescale 1ns / 1ps
// Extended-precision add, subtract and multiply on sign / 16-bit exponent / WORDS x 64-bit
// mantissa floats. Each input transfer loads one word pair (a, b), most significant first,
// one per cycle; the transfer with tlast starts the operation and s_axis_tready stays low
// until the last result word has left. All mantissa state sits in three single-port-read
// RAMs (operand a, operand b, product/result) and every pass walks them one word at a time.
// After the last load transfer: zero fill of unloaded words, operand check, then for
// add/subtract negate, alignment (only when exponents differ), add, magnitude and
// normalise; for multiply the 64x64 partial products (one 32x32 multiplier, W*W products),
// each column's accumulation, then normalise. Results leave as W transfers; each word is
// read from its RAM only after the previous one is taken, and then offered.
module multiword_float_add_mul import mfam_pkg::*; #(
	parameter int WORDS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// sign_a, exp_a, word_a, sign_b, exp_b, word_b
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic [1:0]             s_axis_tuser,
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// res_sign, res_exponent, res_word
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PAW = $clog2(2 * WORDS);
	localparam int IW = PAW + 1;
	localparam int CW = $clog2(WORDS + 1);
	localparam int ACW = 2 * WORD_W + CW + 1;
	localparam int ZW = PAW + 6;

	st_t state_q, state_d;

	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     idx_q;
	logic [AW:0]       ii_q;
	logic [1:0]        m_q;
	logic [1:0]        kind_q;
	logic              sa_q, sb_q;
	logic [EXP_W-1:0]  ea_q, eb_q, ebase_q, eres_q;
	logic              sres_q, zero_q;
	ram_sel_t          out_sel_q;
	logic              ca_q, cb_q, fa_q, fb_q, neg_q;
	ram_sel_t          sh_sel_q;
	logic              sh_left_q, sh_fill_q, sh_norm_q;
	logic [IW-1:0]     sh_qw_q;
	logic [5:0]        sh_r_q;
	logic [IW:0]       sh_n_q;
	logic [WORD_W-1:0] hi_q;
	logic              lz_nz_q;
	logic [PAW-1:0]    lz_idx_q;
	logic [5:0]        lz_clz_q;
	logic [ACW-1:0]    acc_q;
	logic [WORD_W-1:0] pp_q;
	logic [1:0]        pp_sh_q;
	logic              pp_v_q;

	logic              a_we, b_we, p_we, trk;
	logic [AW-1:0]     a_wa, b_wa, a_ra, b_ra;
	logic [PAW-1:0]    p_wa, p_ra;
	logic [WORD_W-1:0] a_wd, b_wd, p_wd, a_rd, b_rd, p_rd;

	logic              in_xfer, out_xfer;
	logic [WORD_W-1:0] word_a, word_b;
	logic [CW-1:0]     cnt_new;
	logic [WORD_W-1:0] sh_rd, fill_w, lo_w, sh_word;
	logic              hi_ok, lo_ok;
	int                hi_i, lo_i, jj, ilo_next;
	logic [WORD_W-1:0] va, vb, vp;
	logic [WORD_W:0]   sum;
	logic [ZW-1:0]     zz;
	logic [16:0]       diff, amt;
	logic [WORD_W-1:0] out_word;
	logic              last_idx, sh_done;

	assign word_a = s_axis_tdata[80:17];
	assign word_b = s_axis_tdata[161:98];
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == ST_LOAD);
	assign m_axis_tvalid = (state_q == ST_OUT_VAL);
	assign cnt_new = (cnt_q < CW'(WORDS)) ? cnt_q + CW'(1) : cnt_q;
	assign last_idx = (idx_q == IW'(WORDS - 1));

	mfam_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram_a (
		.clk(clk), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd), .rd_addr(a_ra), .rd_data(a_rd)
	);
	mfam_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram_b (
		.clk(clk), .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd), .rd_addr(b_ra), .rd_data(b_rd)
	);
	mfam_ram #(.WIDTH(WORD_W), .DEPTH(2 * WORDS)) u_ram_p (
		.clk(clk), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd)
	);

	// shifter addressing and word assembly
	always_comb begin
		if (sh_left_q) begin
			hi_i = int'(idx_q) + int'(sh_qw_q);
			lo_i = hi_i + 1;
			hi_ok = (hi_i < int'(sh_n_q));
			lo_ok = (lo_i < int'(sh_n_q));
			fill_w = '0;
		end else begin
			hi_i = int'(idx_q) - int'(sh_qw_q);
			lo_i = hi_i - 1;
			hi_ok = (hi_i >= 0);
			lo_ok = (lo_i >= 0);
			fill_w = {WORD_W{sh_fill_q}};
		end
		case (sh_sel_q)
			RS_A:    sh_rd = a_rd;
			RS_B:    sh_rd = b_rd;
			default: sh_rd = p_rd;
		endcase
		lo_w = lo_ok ? sh_rd : fill_w;
		if (sh_r_q == 6'd0) begin
			sh_word = hi_q;
		end else if (sh_left_q) begin
			sh_word = (hi_q << sh_r_q) | (lo_w >> (7'd64 - {1'b0, sh_r_q}));
		end else begin
			sh_word = (hi_q >> sh_r_q) | (lo_w << (7'd64 - {1'b0, sh_r_q}));
		end
		sh_done = sh_left_q ? last_idx : (idx_q == '0);
	end

	always_comb begin
		va = sa_q ? (~a_rd + WORD_W'(ca_q)) : a_rd;
		vb = sb_q ? (~b_rd + WORD_W'(cb_q)) : b_rd;
		vp = neg_q ? (~p_rd + WORD_W'(ca_q)) : p_rd;
		sum = {1'b0, a_rd} + {1'b0, b_rd} + (WORD_W + 1)'(ca_q);
		zz = {lz_idx_q, lz_clz_q};
		diff = {ea_q[EXP_W-1], ea_q} - {eb_q[EXP_W-1], eb_q};
		amt = diff[16] ? (17'd0 - diff) : diff;
		jj = int'(idx_q) - int'(ii_q);
		ilo_next = int'(idx_q) - WORDS;
		if (ilo_next < 0) begin
			ilo_next = 0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory ports
	always_comb begin
		state_d = state_q;
		a_we = 1'b0;
		b_we = 1'b0;
		p_we = 1'b0;
		trk = 1'b0;
		a_wa = idx_q[AW-1:0];
		b_wa = idx_q[AW-1:0];
		p_wa = idx_q[PAW-1:0];
		a_wd = '0;
		b_wd = '0;
		p_wd = '0;
		a_ra = idx_q[AW-1:0];
		b_ra = idx_q[AW-1:0];
		p_ra = idx_q[PAW-1:0];
		case (state_q)
			ST_LOAD: begin
				a_wa = cnt_q[AW-1:0];
				b_wa = cnt_q[AW-1:0];
				a_wd = word_a;
				b_wd = word_b;
				if (in_xfer) begin
					a_we = (cnt_q < CW'(WORDS));
					b_we = (cnt_q < CW'(WORDS));
					if (s_axis_tlast) begin
						state_d = (cnt_new < CW'(WORDS)) ? ST_FILL : ST_CHK_RD;
					end
				end
			end
			ST_FILL: begin
				a_we = 1'b1;
				b_we = 1'b1;
				if (last_idx) begin
					state_d = ST_CHK_RD;
				end
			end
			ST_CHK_RD: begin
				a_ra = '0;
				b_ra = '0;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				a_ra = '0;
				b_ra = '0;
				if (kind_q inside {KIND_MUL, KIND_RSV}) begin
					state_d = (a_rd != '0 && b_rd != '0) ? ST_MUL_RD : ST_OUT_RD;
				end else begin
					state_d = (a_rd != '0 && b_rd != '0) ? ST_NEG_RD : ST_OUT_RD;
				end
			end
			ST_NEG_RD: begin
				state_d = ST_NEG_WR;
			end
			ST_NEG_WR: begin
				a_we = 1'b1;
				b_we = 1'b1;
				a_wd = va;
				b_wd = vb;
				state_d = (idx_q == '0) ? ST_ALIGN : ST_NEG_RD;
			end
			ST_ALIGN: begin
				state_d = (diff == '0) ? ST_ADD_RD : ST_SH_RDH;
			end
			ST_SH_RDH: begin
				a_ra = AW'(hi_i);
				b_ra = AW'(hi_i);
				p_ra = PAW'(hi_i);
				state_d = ST_SH_RDL;
			end
			ST_SH_RDL: begin
				a_ra = AW'(lo_i);
				b_ra = AW'(lo_i);
				p_ra = PAW'(lo_i);
				state_d = ST_SH_WR;
			end
			ST_SH_WR: begin
				a_wd = sh_word;
				b_wd = sh_word;
				p_wd = sh_word;
				a_we = (sh_sel_q == RS_A);
				b_we = (sh_sel_q == RS_B);
				p_we = (sh_sel_q == RS_P);
				if (sh_done) begin
					state_d = sh_norm_q ? ST_OUT_RD : ST_ADD_RD;
				end else begin
					state_d = ST_SH_RDH;
				end
			end
			ST_ADD_RD: begin
				state_d = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				p_we = 1'b1;
				p_wd = sum[WORD_W-1:0];
				state_d = (idx_q == '0) ? ST_ABS_RD : ST_ADD_RD;
			end
			ST_ABS_RD: begin
				state_d = ST_ABS_WR;
			end
			ST_ABS_WR: begin
				p_we = 1'b1;
				trk = 1'b1;
				p_wd = vp;
				state_d = (idx_q == '0) ? ST_NORM : ST_ABS_RD;
			end
			ST_MUL_RD, ST_MUL_PP: begin
				a_ra = ii_q[AW-1:0];
				b_ra = AW'(jj);
				if (state_q == ST_MUL_RD) begin
					state_d = ST_MUL_PP;
				end else if (m_q == 2'd3) begin
					if ((int'(ii_q) < int'(idx_q)) && (int'(ii_q) < WORDS - 1)) begin
						state_d = ST_MUL_RD;
					end else begin
						state_d = ST_MUL_ADD;
					end
				end
			end
			ST_MUL_ADD: begin
				state_d = ST_MUL_COL;
			end
			ST_MUL_COL: begin
				p_we = 1'b1;
				trk = 1'b1;
				p_wa = PAW'(int'(idx_q) + 1);
				p_wd = acc_q[WORD_W-1:0];
				state_d = (idx_q == '0) ? ST_MUL_TOP : ST_MUL_RD;
			end
			ST_MUL_TOP: begin
				p_we = 1'b1;
				trk = 1'b1;
				p_wa = '0;
				p_wd = acc_q[WORD_W-1:0];
				state_d = ST_NORM;
			end
			ST_NORM: begin
				state_d = lz_nz_q ? ST_SH_RDH : ST_OUT_RD;
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_VAL;
			end
			ST_OUT_VAL: begin
				if (out_xfer) begin
					state_d = last_idx ? ST_LOAD : ST_OUT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			ii_q <= '0;
			m_q <= '0;
			pp_v_q <= 1'b0;
			lz_nz_q <= 1'b0;
			zero_q <= 1'b0;
			out_sel_q <= RS_P;
			sh_sel_q <= RS_P;
			sh_left_q <= 1'b0;
			sh_norm_q <= 1'b0;
		end else begin
			pp_v_q <= 1'b0;
			if (p_we && trk && p_wd != '0) begin
				lz_nz_q <= 1'b1;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						cnt_q <= s_axis_tlast ? '0 : cnt_new;
						idx_q <= IW'(cnt_new);
					end
				end
				ST_FILL: begin
					idx_q <= idx_q + IW'(1);
				end
				ST_CHK: begin
					lz_nz_q <= 1'b0;
					if (kind_q inside {KIND_MUL, KIND_RSV}) begin
						idx_q <= (a_rd == '0 || b_rd == '0) ? '0 : IW'(2 * WORDS - 2);
						ii_q <= (AW + 1)'(WORDS - 1);
						m_q <= '0;
						zero_q <= (a_rd == '0 || b_rd == '0);
						out_sel_q <= RS_P;
					end else if (a_rd != '0 && b_rd != '0) begin
						idx_q <= IW'(WORDS - 1);
						zero_q <= 1'b0;
						out_sel_q <= RS_P;
					end else begin
						idx_q <= '0;
						if (a_rd == '0) begin
							out_sel_q <= RS_B;
							zero_q <= (b_rd == '0);
						end else begin
							out_sel_q <= RS_A;
							zero_q <= 1'b0;
						end
					end
				end
				ST_NEG_WR: begin
					if (idx_q != '0) begin
						idx_q <= idx_q - IW'(1);
					end
				end
				ST_ALIGN: begin
					idx_q <= IW'(WORDS - 1);
					sh_left_q <= 1'b0;
					sh_norm_q <= 1'b0;
					sh_sel_q <= diff[16] ? RS_A : RS_B;
				end
				ST_SH_WR: begin
					if (sh_done) begin
						idx_q <= sh_norm_q ? '0 : IW'(WORDS - 1);
					end else if (sh_left_q) begin
						idx_q <= idx_q + IW'(1);
					end else begin
						idx_q <= idx_q - IW'(1);
					end
				end
				ST_ADD_WR: begin
					idx_q <= (idx_q == '0) ? IW'(WORDS - 1) : idx_q - IW'(1);
				end
				ST_ABS_WR: begin
					if (idx_q != '0) begin
						idx_q <= idx_q - IW'(1);
					end
				end
				ST_MUL_PP: begin
					m_q <= m_q + 2'd1;
					pp_v_q <= 1'b1;
					if (m_q == 2'd3) begin
						ii_q <= ii_q + (AW + 1)'(1);
					end
				end
				ST_MUL_COL: begin
					if (idx_q != '0) begin
						idx_q <= idx_q - IW'(1);
						ii_q <= (AW + 1)'(ilo_next);
					end
				end
				ST_NORM: begin
					zero_q <= !lz_nz_q;
					sh_sel_q <= RS_P;
					sh_norm_q <= 1'b1;
					sh_left_q <= (zz >= ZW'(NORM_LZ));
					idx_q <= (!lz_nz_q || zz >= ZW'(NORM_LZ)) ? '0 : IW'(WORDS - 1);
				end
				ST_OUT_VAL: begin
					if (out_xfer) begin
						idx_q <= last_idx ? '0 : idx_q + IW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// operation context and arithmetic registers
	always_ff @(posedge clk) begin
		if (p_we && trk && p_wd != '0) begin
			lz_idx_q <= p_wa;
			lz_clz_q <= clz64(p_wd);
		end
		if (pp_v_q) begin
			case (pp_sh_q)
				2'd0:    acc_q <= acc_q + ACW'(pp_q);
				2'd1:    acc_q <= acc_q + (ACW'(pp_q) << HALF_W);
				default: acc_q <= acc_q + (ACW'(pp_q) << WORD_W);
			endcase
		end
		case (state_q)
			ST_LOAD: begin
				if (in_xfer && s_axis_tlast) begin
					kind_q <= s_axis_tuser;
					sa_q <= s_axis_tdata[0];
					ea_q <= s_axis_tdata[16:1];
					sb_q <= s_axis_tdata[81];
					eb_q <= s_axis_tdata[97:82];
				end
			end
			ST_CHK: begin
				ca_q <= 1'b1;
				cb_q <= 1'b1;
				acc_q <= '0;
				if (!(kind_q inside {KIND_MUL, KIND_RSV})) begin
					sb_q <= sb_q ^ (kind_q == KIND_SUB);
					if (a_rd == '0) begin
						sres_q <= sb_q ^ (kind_q == KIND_SUB);
						eres_q <= eb_q;
					end else begin
						sres_q <= sa_q;
						eres_q <= ea_q;
					end
				end
			end
			ST_NEG_WR: begin
				ca_q <= ca_q & (va == '0);
				cb_q <= cb_q & (vb == '0);
				fa_q <= va[WORD_W-1];
				fb_q <= vb[WORD_W-1];
			end
			ST_ALIGN: begin
				ebase_q <= diff[16] ? eb_q : ea_q;
				sh_fill_q <= diff[16] ? fa_q : fb_q;
				sh_r_q <= amt[5:0];
				sh_n_q <= (IW + 1)'(WORDS);
				sh_qw_q <= (amt[16:6] > 11'(WORDS)) ? IW'(WORDS) : IW'(amt[16:6]);
				ca_q <= 1'b0;
			end
			ST_ADD_WR: begin
				ca_q <= (idx_q == '0) ? 1'b1 : sum[WORD_W];
				if (idx_q == '0) begin
					neg_q <= sum[WORD_W-1];
				end
			end
			ST_ABS_WR: begin
				ca_q <= ca_q & (vp == '0);
			end
			ST_SH_RDL: begin
				hi_q <= hi_ok ? sh_rd : fill_w;
			end
			ST_MUL_PP: begin
				pp_q <= (m_q[1] ? a_rd[WORD_W-1:HALF_W] : a_rd[HALF_W-1:0]) *
					(m_q[0] ? b_rd[WORD_W-1:HALF_W] : b_rd[HALF_W-1:0]);
				pp_sh_q <= {1'b0, m_q[1]} + {1'b0, m_q[0]};
			end
			ST_MUL_COL: begin
				acc_q <= acc_q >> WORD_W;
			end
			ST_NORM: begin
				sh_fill_q <= 1'b0;
				sh_n_q <= (kind_q inside {KIND_MUL, KIND_RSV}) ?
					(IW + 1)'(2 * WORDS) : (IW + 1)'(WORDS);
				if (zz >= ZW'(NORM_LZ)) begin
					sh_qw_q <= IW'((zz - ZW'(NORM_LZ)) >> 6);
					sh_r_q <= zz[5:0] - 6'(NORM_LZ);
				end else begin
					sh_qw_q <= '0;
					sh_r_q <= 6'(NORM_LZ) - zz[5:0];
				end
				if (kind_q inside {KIND_MUL, KIND_RSV}) begin
					sres_q <= sa_q ^ sb_q;
					eres_q <= ea_q + eb_q + EXP_W'(2 * NORM_LZ) - EXP_W'(zz);
				end else begin
					sres_q <= neg_q;
					eres_q <= ebase_q + EXP_W'(NORM_LZ) - EXP_W'(zz);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (out_sel_q)
			RS_A:    out_word = a_rd;
			RS_B:    out_word = b_rd;
			default: out_word = p_rd;
		endcase
		if (zero_q) begin
			m_axis_tdata = '0;
		end else begin
			m_axis_tdata = {7'd0, out_word, eres_q, sres_q};
		end
		m_axis_tlast = last_idx;
	end

endmodule

/* hw/rtl/mfam_checker.sv */
`timescale 1ns / 1ps
`include "multiword_float_add_mul_assert.svh"
module mfam_checker import mfam_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   s_axis_tlast,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tlast
);

	`MFAM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
	`MFAM_ASSERT_SAME(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input taken while results pending")
	`MFAM_ASSERT_NEXT(a_end_of_result, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "result beyond last word")
	`MFAM_ASSERT_NEXT(a_start_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken during operation")

endmodule

bind multiword_float_add_mul mfam_checker u_mfam_checker (.*);

/* tb/multiword_float_add_mul_test.sv */
`timescale 1ns / 1ps
module multiword_float_add_mul_test;
	import mfam_pkg::*;

	localparam int NW = 4;

	typedef struct {
		logic [1:0]  kind;
		logic        sa;
		logic [15:0] ea;
		logic [63:0] wa;
		logic        sb;
		logic [15:0] eb;
		logic [63:0] wb;
		logic        last;
		bit          hold;
	} load_t;

	typedef struct {
		logic        sign;
		logic [15:0] expo;
		logic [63:0] word;
		logic        last;
	} rword_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic s_axis_tlast = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	load_t pending[$];
	rword_t result_q[$];
	logic [63:0] word_a_mem[NW];
	logic [63:0] word_b_mem[NW];
	int nloaded = 0;
	int errors = 0;
	int sent = 0;
	bit took = 0;
	load_t cur;

	multiword_float_add_mul #(.WORDS(NW)) dut (.*);

	always #6 clk = ~clk;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int lead0(input logic [511:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			if (v[i]) return n - 1 - i;
		return n;
	endfunction

	task automatic fp_compute(input load_t it);
		logic [255:0] ma, mb, r;
		logic [511:0] p;
		logic sign, sb;
		int e, diff, z, s;
		rword_t w;
		ma = {word_a_mem[0], word_a_mem[1], word_a_mem[2], word_a_mem[3]};
		mb = {word_b_mem[0], word_b_mem[1], word_b_mem[2], word_b_mem[3]};
		sign = 0;
		e = 0;
		r = '0;
		if (it.kind == KIND_MUL || it.kind == KIND_RSV) begin
			if (ma[255:192] != 0 && mb[255:192] != 0) begin
				p = {256'b0, ma} * {256'b0, mb};
				s = lead0(p, 512) - 2;
				p = (s >= 0) ? (p << s) : (p >> -s);
				r = p[511:256];
				sign = it.sa ^ it.sb;
				e = $signed(it.ea) + $signed(it.eb) - (s - 2);
			end
		end else begin
			sb = it.sb ^ (it.kind == KIND_SUB);
			if (ma[255:192] != 0 && mb[255:192] != 0) begin
				e = $signed(it.ea);
				diff = $signed(it.ea) - $signed(it.eb);
				if (it.sa) ma = -ma;
				if (sb) mb = -mb;
				if (diff > 0) mb = $signed(mb) >>> diff;
				else if (diff < 0) begin
					e = $signed(it.eb);
					ma = $signed(ma) >>> (-diff);
				end
				r = ma + mb;
				if (r[255]) begin
					sign = 1;
					r = -r;
				end
				z = lead0({256'b0, r}, 256);
				if (z >= 256) begin
					sign = 0;
					e = 0;
				end else begin
					r = (z >= 2) ? (r << (z - 2)) : (r >> (2 - z));
					e = e - (z - 2);
				end
			end else if (ma[255:192] == 0) begin
				r = mb;
				sign = sb;
				e = $signed(it.eb);
			end else begin
				r = ma;
				sign = it.sa;
				e = $signed(it.ea);
			end
		end
		if (r[255:192] == 0) begin
			r = '0;
			sign = 0;
			e = 0;
		end
		for (int k = 0; k < NW; k++) begin
			w.sign = sign;
			w.expo = e[15:0];
			w.word = r[255 - 64*k -: 64];
			w.last = (k == NW - 1);
			result_q.push_back(w);
		end
	endtask

	// accepted transfers feed the predictor
	always @(posedge clk) begin
		took = s_axis_tvalid && s_axis_tready;
		if (took) begin
			if (nloaded < NW) begin
				word_a_mem[nloaded] = cur.wa;
				word_b_mem[nloaded] = cur.wb;
				nloaded++;
			end
			if (cur.last) begin
				for (int i = nloaded; i < NW; i++) begin
					word_a_mem[i] = '0;
					word_b_mem[i] = '0;
				end
				nloaded = 0;
				fp_compute(cur);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			m_axis_tready <= (sent > 40 && sent < 75) || ($urandom_range(0, 99) >= 7);
			if (!s_axis_tvalid || took) begin
				if (pending.size() == 0 || (sent < 75 && sent > 40 ? 0 : $urandom_range(0, 99) < 7)
						|| (pending[0].hold && result_q.size() != 0)) begin
					s_axis_tvalid <= 0;
				end else begin
					cur = pending.pop_front();
					sent++;
					s_axis_tvalid <= 1;
					s_axis_tdata <= {6'b0, cur.wb, cur.eb, cur.sb, cur.wa, cur.ea, cur.sa};
					s_axis_tuser <= cur.kind;
					s_axis_tlast <= cur.last;
				end
			end
		end
	end

	always @(posedge clk) begin
		rword_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (result_q.size() == 0) begin
				report("unexpected transfer", m_axis_tdata[80:17], 64'h0);
			end else begin
				w = result_q.pop_front();
				if (m_axis_tdata[0] !== w.sign) report("sign", m_axis_tdata[0], w.sign);
				if (m_axis_tdata[16:1] !== w.expo) report("exponent", m_axis_tdata[16:1], w.expo);
				if (m_axis_tdata[80:17] !== w.word) report("word", m_axis_tdata[80:17], w.word);
				if (m_axis_tlast !== w.last) report("tlast", m_axis_tlast, w.last);
			end
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] fmt_word();
		logic [63:0] r;
		r = rnd64();
		return {3'b001, r[60:0]};
	endfunction

	function automatic logic [63:0] lead_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return rnd64();
			default: return fmt_word();
		endcase
	endfunction

	task automatic push_op(input logic [1:0] kind, input logic sa, input logic [15:0] ea,
			input logic sb, input logic [15:0] eb, input logic [63:0] a[6],
			input logic [63:0] b[6], input int n, input bit hold);
		load_t it;
		for (int i = 0; i < n; i++) begin
			it.kind = 2'($urandom);
			it.sa = 1'($urandom);
			it.ea = 16'($urandom);
			it.sb = 1'($urandom);
			it.eb = 16'($urandom);
			it.wa = a[i];
			it.wb = b[i];
			it.last = (i == n - 1);
			it.hold = hold && (i == 0);
			if (it.last) begin
				it.kind = kind;
				it.sa = sa;
				it.ea = ea;
				it.sb = sb;
				it.eb = eb;
			end
			pending.push_back(it);
		end
	endtask

	initial begin
		logic [63:0] a[6], b[6];
		logic [15:0] ea, eb;
		int n, cnt;
		for (int i = 0; i < 6; i++) begin
			a[i] = fmt_word();
			b[i] = fmt_word();
		end
		push_op(KIND_ADD, 1, 16'h7fff, 1, 16'h8000, a, b, 4, 0);
		push_op(KIND_SUB, 0, 16'd5, 0, 16'd5, a, a, 4, 0);
		push_op(KIND_MUL, 1, 16'h7fff, 0, 16'h7fff, a, b, 1, 0);
		push_op(KIND_RSV, 0, 16'h8000, 1, 16'h8000, a, b, 6, 0);
		a[0] = '0;
		push_op(KIND_ADD, 0, 16'd3, 1, 16'd9, a, b, 2, 0);
		push_op(KIND_SUB, 1, 16'd3, 1, 16'd9, b, a, 2, 0);
		push_op(KIND_MUL, 0, 16'd1, 0, 16'd1, a, b, 3, 0);
		push_op(KIND_ADD, 0, 16'd0, 1, 16'd0, a, a, 1, 0);
		a[0] = '1;
		b[0] = 64'hc000_0000_0000_0001;
		push_op(KIND_ADD, 0, 16'd100, 0, 16'hff00, a, b, 4, 0);
		push_op(KIND_MUL, 1, 16'd0, 1, 16'd2, a, b, 4, 0);
		cnt = 0;
		while (cnt < 90) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : NW;
			a[0] = lead_word();
			b[0] = lead_word();
			for (int i = 1; i < 6; i++) begin
				a[i] = ($urandom_range(0, 7) == 0) ? '1 : rnd64();
				b[i] = ($urandom_range(0, 7) == 0) ? '0 : rnd64();
			end
			ea = 16'($urandom);
			eb = ($urandom_range(0, 1) == 0) ? ea + 16'($urandom_range(0, 8)) - 16'd4 : 16'($urandom);
			if ($urandom_range(0, 7) == 0) begin
				b = a;
				eb = ea;
			end
			push_op(2'($urandom_range(0, 3)), 1'($urandom), ea, 1'($urandom), eb, a, b, n,
				cnt > 60 && cnt < 66);
			cnt += n;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (pending.size() == 0 && result_q.size() == 0 && !s_axis_tvalid);
		repeat (1000) @(posedge clk);
		if (errors == 0 && result_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#8000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mfam_pkg.sv
hw/rtl/mfam_ram.sv
hw/rtl/multiword_float_add_mul.sv
hw/rtl/mfam_checker.sv
tb/multiword_float_add_mul_test.sv
